>>> rtl/afk_pkg.sv
`timescale 1ns / 1ps

package afk_pkg;

	// Default widths of the joint angles and link lengths
	localparam int DEF_ANGLE_BITS  = 16;
	localparam int DEF_LENGTH_BITS = 16;

	// Result fields: signed Q4.16 metres
	localparam int     OUT_W   = 20;
	localparam longint OUT_MAX = 524287;
	localparam longint OUT_MIN = -524288;

	// Sine/cosine unit: Q4.30 datapath, 32-bit binary angle residual
	localparam int CORDIC_STEPS = 18;
	localparam int XW           = 34;
	localparam int ZW           = 33;
	localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215
	};

	// Register stages between input beat and the result mux:
	// input fold, one per rotation, rounding, four in the multiply path
	localparam int PIPE_STAGES = CORDIC_STEPS + 6;

	// Default link length 0.13335 m as Q0.32
	localparam longint LINK_DEFAULT_Q32 = 64'sd572733889;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_HEIGHT = 2'd0,
		REG_UPPER_LINK  = 2'd1,
		REG_LOWER_LINK  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] s;
		logic signed [15:0] c;
	} sincos_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
	} tip_t;

	// Reset value of a link register, rounded from Q0.32
	function automatic longint link_reset(input int lb);
		return (LINK_DEFAULT_Q32 + (longint'(1) << (31 - lb))) >> (32 - lb);
	endfunction

	// Clamp to the signed Q4.16 output range
	function automatic logic signed [OUT_W-1:0] sat_out(input longint v);
		logic signed [OUT_W-1:0] r;
		if (v > OUT_MAX) begin
			r = OUT_W'(OUT_MAX);
		end else if (v < OUT_MIN) begin
			r = OUT_W'(OUT_MIN);
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

endpackage

>>> rtl/afk_intf.sv
`timescale 1ns / 1ps

// Joint angle channel
interface afk_in_if #(parameter int ANGLE_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] base_angle;
	logic signed [ANGLE_BITS-1:0] shoulder_angle;
	logic signed [ANGLE_BITS-1:0] elbow_angle;

	modport source (output valid, base_angle, shoulder_angle, elbow_angle, input ready);
	modport sink   (input valid, base_angle, shoulder_angle, elbow_angle, output ready);
endinterface

// Tip position channel
interface afk_out_if import afk_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] tip_x;
	logic signed [OUT_W-1:0] tip_y;
	logic signed [OUT_W-1:0] tip_z;

	modport source (output valid, tip_x, tip_y, tip_z, input ready);
	modport sink   (input valid, tip_x, tip_y, tip_z, output ready);
endinterface

// Register write channel
interface afk_cfg_if import afk_pkg::*; #(parameter int DATA_BITS = 16);
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/afk_cordic.sv
`timescale 1ns / 1ps

// Pipelined rotation-mode CORDIC: one register stage per rotation.
// Angle is a 32-bit binary angle; output is Q1.15 sine and cosine.
module afk_cordic import afk_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] angle,
	output sincos_t     sc
);

	localparam logic signed [XW-1:0] Q15_HALF = 34'sd16384;

	logic                  fold;
	logic [31:0]           a_fold;
	logic signed [ZW-1:0]  z0_s;
	logic                  flip_s [CORDIC_STEPS+1];
	logic signed [XW-1:0]  x_s    [CORDIC_STEPS];
	logic signed [XW-1:0]  y_s    [CORDIC_STEPS];
	logic signed [ZW-1:0]  z_s    [CORDIC_STEPS-1];
	logic signed [XW-1:0]  xin    [CORDIC_STEPS];
	logic signed [XW-1:0]  yin    [CORDIC_STEPS];
	logic signed [ZW-1:0]  zin    [CORDIC_STEPS];
	logic signed [XW-1:0]  x_nx   [CORDIC_STEPS];
	logic signed [XW-1:0]  y_nx   [CORDIC_STEPS];
	logic signed [ZW-1:0]  z_nx   [CORDIC_STEPS-1];
	logic signed [XW-1:0]  xr, yr;
	sincos_t               sc_s;

	function automatic logic signed [15:0] round_q15(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] t;
		logic signed [15:0]   r;
		t = (v + Q15_HALF) >>> 15;
		if (t > 32767) begin
			r = 16'sd32767;
		end else if (t < -32767) begin
			r = -16'sd32767;
		end else begin
			r = 16'(t);
		end
		return r;
	endfunction

	// Angles beyond +-pi/2 are turned by pi and the result negated
	assign fold   = angle[31] ^ angle[30];
	assign a_fold = fold ? (angle ^ 32'h8000_0000) : angle;

	// Stage inputs: first rotation starts from the gain constant
	always_comb begin
		xin[0] = CORDIC_GAIN;
		yin[0] = '0;
		zin[0] = z0_s;
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			xin[i] = x_s[i-1];
			yin[i] = y_s[i-1];
			zin[i] = z_s[i-1];
		end
	end

	// One micro-rotation per stage
	always_comb begin
		logic signed [XW-1:0] dx, dy;
		logic signed [ZW-1:0] at;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = yin[i] >>> i;
			dy = xin[i] >>> i;
			if (!zin[i][ZW-1]) begin
				x_nx[i] = xin[i] - dx;
				y_nx[i] = yin[i] + dy;
			end else begin
				x_nx[i] = xin[i] + dx;
				y_nx[i] = yin[i] - dy;
			end
		end
		for (int i = 0; i < CORDIC_STEPS - 1; i++) begin
			at = $signed({1'b0, ATAN_TAB[i]});
			z_nx[i] = zin[i][ZW-1] ? (zin[i] + at) : (zin[i] - at);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z0_s      <= ZW'(signed'(a_fold));
			flip_s[0] <= fold;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				x_s[i]      <= x_nx[i];
				y_s[i]      <= y_nx[i];
				flip_s[i+1] <= flip_s[i];
			end
			for (int i = 0; i < CORDIC_STEPS - 1; i++) begin
				z_s[i] <= z_nx[i];
			end
		end
	end

	// Undo the fold, round to Q1.15
	assign xr = flip_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS-1] : x_s[CORDIC_STEPS-1];
	assign yr = flip_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS-1] : y_s[CORDIC_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s.c <= round_q15(xr);
			sc_s.s <= round_q15(yr);
		end
	end

	assign sc = sc_s;

endmodule

>>> rtl/afk_mac.sv
`timescale 1ns / 1ps

// Link products, planar reach and height, then the base rotation.
// Four register stages; the final rounding and clamp of x and y are combinational.
module afk_mac import afk_pkg::*; #(
	parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [LENGTH_BITS-1:0] l1,
	input  logic [LENGTH_BITS-1:0] l2,
	input  logic [LENGTH_BITS-1:0] l3,
	input  sincos_t                sc_b,
	input  sincos_t                sc_s,
	input  sincos_t                sc_se,
	output tip_t                   tip
);

	localparam int PW   = LENGTH_BITS + 17;   // length x Q1.15
	localparam int RW   = LENGTH_BITS + 18;   // reach
	localparam int ZFW  = LENGTH_BITS + 19;   // height before rounding
	localparam int ZRW  = ZFW + 1;
	localparam int PLW  = 33;                 // trig x low 16 bits of reach
	localparam int PHW  = LENGTH_BITS + 18;   // trig x high part of reach
	localparam int XPW  = LENGTH_BITS + 34;   // full planar product
	localparam int XRW  = XPW + 1;
	localparam logic signed [ZRW-1:0] ZHALF = ZRW'(longint'(1) << (LENGTH_BITS - 2));
	localparam logic signed [XRW-1:0] XHALF = XRW'(longint'(1) << (LENGTH_BITS + 13));

	// stage 1: link products
	logic signed [PW-1:0]  p2c_s1, p3c_s1, p2s_s1, p3s_s1;
	logic signed [15:0]    cb_s1, sb_s1;
	// stage 2: reach and height sums
	logic signed [RW-1:0]  r_s2;
	logic signed [ZFW-1:0] zf_s2;
	logic signed [15:0]    cb_s2, sb_s2;
	// stage 3: split products, height rounded
	logic signed [PLW-1:0] plo_x_s3, plo_y_s3;
	logic signed [PHW-1:0] phi_x_s3, phi_y_s3;
	logic signed [OUT_W-1:0] z_s3;
	// stage 4: full products
	logic signed [XPW-1:0] xp_s4, yp_s4;
	logic signed [OUT_W-1:0] z_s4;

	logic signed [ZRW-1:0] zr;
	logic signed [XRW-1:0] xr, yr;
	logic signed [16:0]    r_lo;
	logic signed [RW-17:0] r_hi;

	always_ff @(posedge clk) begin
		if (en) begin
			p2c_s1 <= signed'({1'b0, l2}) * sc_s.c;
			p3c_s1 <= signed'({1'b0, l3}) * sc_se.c;
			p2s_s1 <= signed'({1'b0, l2}) * sc_s.s;
			p3s_s1 <= signed'({1'b0, l3}) * sc_se.s;
			cb_s1  <= sc_b.c;
			sb_s1  <= sc_b.s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2  <= RW'(p2c_s1) + RW'(p3c_s1);
			zf_s2 <= ZFW'(signed'({1'b0, l1, 15'b0})) + ZFW'(p2s_s1) + ZFW'(p3s_s1);
			cb_s2 <= cb_s1;
			sb_s2 <= sb_s1;
		end
	end

	// Reach split in two so each multiplier stays narrow
	assign r_lo = signed'({1'b0, r_s2[15:0]});
	assign r_hi = signed'(r_s2[RW-1:16]);
	assign zr   = (ZRW'(zf_s2) + ZHALF) >>> (LENGTH_BITS - 1);

	always_ff @(posedge clk) begin
		if (en) begin
			plo_x_s3 <= cb_s2 * r_lo;
			plo_y_s3 <= sb_s2 * r_lo;
			phi_x_s3 <= cb_s2 * r_hi;
			phi_y_s3 <= sb_s2 * r_hi;
			z_s3     <= sat_out(longint'(zr));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s4 <= (XPW'(phi_x_s3) <<< 16) + XPW'(plo_x_s3);
			yp_s4 <= (XPW'(phi_y_s3) <<< 16) + XPW'(plo_y_s3);
			z_s4  <= z_s3;
		end
	end

	// Round to Q4.16 and clamp
	assign xr = (XRW'(xp_s4) + XHALF) >>> (LENGTH_BITS + 14);
	assign yr = (XRW'(yp_s4) + XHALF) >>> (LENGTH_BITS + 14);

	assign tip.x = sat_out(longint'(xr));
	assign tip.y = sat_out(longint'(yr));
	assign tip.z = z_s4;

endmodule

>>> rtl/arm_forward_kinematics_3dof_core.sv
// Each input beat runs through the 24-stage pipeline (18 CORDIC rotations), then the output register.
// Throughput: one beat per cycle while the skid entry is free.
// An output register plus one skid entry decouple the sides; input ready drops only
// while the skid entry is occupied, which freezes the whole pipeline.
// Reset (arst_n low, asynchronous): pipeline and output empty, link registers to
// round(0.13335 * 2^LENGTH_BITS).
`timescale 1ns / 1ps

module arm_forward_kinematics_3dof_core import afk_pkg::*; #(
	parameter int ANGLE_BITS  = DEF_ANGLE_BITS,
	parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	afk_in_if.sink     in_ch,
	afk_out_if.source  out_ch,
	afk_cfg_if.sink    cfg
);

	localparam logic [LENGTH_BITS-1:0] LINK_RST = LENGTH_BITS'(link_reset(LENGTH_BITS));

	logic [LENGTH_BITS-1:0] base_height_q, upper_link_q, lower_link_q;
	logic [PIPE_STAGES-1:0] vld_s;
	logic                   en;
	logic [31:0]            bam_b, bam_s, bam_e, bam_se;
	sincos_t                sc_b, sc_s, sc_se;
	tip_t                   res;
	tip_t                   out_q, skid_q;
	logic                   out_valid_q, skid_valid_q;
	logic                   take, last_vld;

	// Link registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q <= LINK_RST;
			upper_link_q  <= LINK_RST;
			lower_link_q  <= LINK_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_BASE_HEIGHT: base_height_q <= cfg.data;
				REG_UPPER_LINK:  upper_link_q  <= cfg.data;
				REG_LOWER_LINK:  lower_link_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Pipeline advances whenever the skid entry is free
	assign en          = !skid_valid_q;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_STAGES-2:0], in_ch.valid};
		end
	end

	// Binary angles in the top bits of a 32-bit word; elbow sum wraps
	assign bam_b  = {in_ch.base_angle,     {(32 - ANGLE_BITS){1'b0}}};
	assign bam_s  = {in_ch.shoulder_angle, {(32 - ANGLE_BITS){1'b0}}};
	assign bam_e  = {in_ch.elbow_angle,    {(32 - ANGLE_BITS){1'b0}}};
	assign bam_se = bam_s + bam_e;

	afk_cordic u_cordic_base (
		.clk   (clk),
		.en    (en),
		.angle (bam_b),
		.sc    (sc_b)
	);

	afk_cordic u_cordic_shoulder (
		.clk   (clk),
		.en    (en),
		.angle (bam_s),
		.sc    (sc_s)
	);

	afk_cordic u_cordic_elbow (
		.clk   (clk),
		.en    (en),
		.angle (bam_se),
		.sc    (sc_se)
	);

	afk_mac #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_mac (
		.clk   (clk),
		.en    (en),
		.l1    (base_height_q),
		.l2    (upper_link_q),
		.l3    (lower_link_q),
		.sc_b  (sc_b),
		.sc_s  (sc_s),
		.sc_se (sc_se),
		.tip   (res)
	);

	// Output register with one skid entry
	assign last_vld = vld_s[PIPE_STAGES-1];
	assign take     = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= en && last_vld;
			end
		end else if (en && last_vld) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (en && last_vld) begin
			skid_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.tip_x = out_q.x;
	assign out_ch.tip_y = out_q.y;
	assign out_ch.tip_z = out_q.z;

	// Checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(en && last_vld && out_valid_q && !out_ch.ready) |=> skid_valid_q)
		else $error("result leaving pipeline into a stalled output was dropped");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> vld_s[0])
		else $error("accepted beat did not enter the pipeline");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import afk_pkg::*;

	localparam int ANG_W = DEF_ANGLE_BITS;
	localparam int LEN_W = DEF_LENGTH_BITS;
	// 0.13335 m rounded to Q0.16
	localparam logic [LEN_W-1:0] LINK_AT_RESET = 16'd8739;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int  TAIL_CYCLES = 40;
	localparam int  HOLD_CYCLES = 300;
	localparam int  CHUNK_ITEMS = 70;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;

	afk_in_if  #(.ANGLE_BITS(ANG_W)) in_ch ();
	afk_out_if                       out_ch ();
	afk_cfg_if #(.DATA_BITS(LEN_W))  cfg_ch ();

	arm_forward_kinematics_3dof_core #(
		.ANGLE_BITS  (ANG_W),
		.LENGTH_BITS (LEN_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the link registers
	logic [LEN_W-1:0] base_h;
	logic [LEN_W-1:0] upper_l;
	logic [LEN_W-1:0] lower_l;

	tip_t   pending_tips[$];
	int     mismatch_count = 0;
	int     tx_idle_pct    = 0;
	int     rx_idle_pct    = 0;
	int     hold_left;
	logic   hold_go        = 1'b0;
	longint cycles         = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Long output hold-off, counted here so the sender keeps pushing meanwhile
	initial begin
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (hold_go) begin
				hold_left <= HOLD_CYCLES;
			end
		end
	end

	// Receiver: random stalls on the result channel
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
		mismatch_count++;
	endtask

	// Sine/cosine of a 32-bit binary angle, Q1.15
	function automatic void sin_cos(input logic [31:0] bam, output longint sin_q,
			output longint cos_q);
		logic [31:0] a;
		bit     flip;
		longint x, y, z, dx, dy;
		a    = bam;
		flip = 1'b0;
		// fold the back half-plane onto the front one
		if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
			a    = a - 32'h8000_0000;
			flip = 1'b1;
		end
		z = longint'($signed(a));
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(ATAN_TAB[i]);
			end else begin
				x += dx;
				y -= dy;
				z += longint'(ATAN_TAB[i]);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		cos_q = (x + 64'sd16384) >>> 15;
		sin_q = (y + 64'sd16384) >>> 15;
		if (cos_q > 32767) cos_q = 32767;
		if (cos_q < -32767) cos_q = -32767;
		if (sin_q > 32767) sin_q = 32767;
		if (sin_q < -32767) sin_q = -32767;
	endfunction

	// Round half up by sh bits and clamp to Q4.16
	function automatic logic signed [OUT_W-1:0] to_tip(input longint v, input int sh);
		longint r;
		r = (v + (longint'(1) << (sh - 1))) >>> sh;
		if (r > OUT_MAX) r = OUT_MAX;
		if (r < OUT_MIN) r = OUT_MIN;
		return OUT_W'(r);
	endfunction

	function automatic tip_t predict_tip(input logic [ANG_W-1:0] b, input logic [ANG_W-1:0] s,
			input logic [ANG_W-1:0] e);
		logic [31:0] bam_b, bam_s, bam_se;
		longint sb, cb, ss, cs, sse, cse, reach, height;
		tip_t   tip;
		bam_b  = {b, {(32-ANG_W){1'b0}}};
		bam_s  = {s, {(32-ANG_W){1'b0}}};
		// elbow adds on the shoulder, wrapping modulo a full turn
		bam_se = bam_s + {e, {(32-ANG_W){1'b0}}};
		sin_cos(bam_b, sb, cb);
		sin_cos(bam_s, ss, cs);
		sin_cos(bam_se, sse, cse);
		reach  = longint'(upper_l) * cs + longint'(lower_l) * cse;
		height = longint'(base_h) * 32768 + longint'(upper_l) * ss + longint'(lower_l) * sse;
		tip.x  = to_tip(cb * reach, 14 + LEN_W);
		tip.y  = to_tip(sb * reach, 14 + LEN_W);
		tip.z  = to_tip(height, LEN_W - 1);
		return tip;
	endfunction

	// Mostly uniform angles, some around the quadrant edges and the extremes
	function automatic logic [ANG_W-1:0] pick_angle();
		logic [ANG_W-1:0] corner;
		case ($urandom_range(7))
			0: begin
				corner = ANG_W'($urandom_range(3)) << (ANG_W - 2);
				return corner + ANG_W'($urandom_range(4)) - ANG_W'(2);
			end
			1: return $urandom_range(1) ? {1'b0, {(ANG_W-1){1'b1}}} : {1'b1, {(ANG_W-1){1'b0}}};
			default: return ANG_W'($urandom);
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return LEN_W'($urandom);
		endcase
	endfunction

	// Check each result beat against the oldest predicted tip
	always @(posedge clk) begin : check_beat
		tip_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_tips.size() == 0) begin
				report_mismatch("unexpected beat, tip_x", out_ch.tip_x, 0);
			end else begin
				want = pending_tips.pop_front();
				if (out_ch.tip_x !== want.x) report_mismatch("tip_x", out_ch.tip_x, want.x);
				if (out_ch.tip_y !== want.y) report_mismatch("tip_y", out_ch.tip_y, want.y);
				if (out_ch.tip_z !== want.z) report_mismatch("tip_z", out_ch.tip_z, want.z);
			end
		end
	end

	// One joint-angle beat; valid stays up unless a gap is drawn
	task automatic send_angles(input logic [ANG_W-1:0] b, input logic [ANG_W-1:0] s,
			input logic [ANG_W-1:0] e);
		in_ch.valid          <= 1'b1;
		in_ch.base_angle     <= b;
		in_ch.shoulder_angle <= s;
		in_ch.elbow_angle    <= e;
		do @(posedge clk); while (!in_ch.ready);
		pending_tips.insert(pending_tips.size(), predict_tip(b, s, e));
		if ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_tips.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val,
			input bit more);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (!more) cfg_ch.valid <= 1'b0;
		case (idx)
			REG_BASE_HEIGHT: base_h  = val;
			REG_UPPER_LINK:  upper_l = val;
			REG_LOWER_LINK:  lower_l = val;
			default: ;
		endcase
	endtask

	task automatic set_lengths(input logic [LEN_W-1:0] h, input logic [LEN_W-1:0] u,
			input logic [LEN_W-1:0] l);
		write_reg(REG_BASE_HEIGHT, h, 1'b1);
		write_reg(REG_UPPER_LINK, u, 1'b1);
		write_reg(REG_LOWER_LINK, l, 1'b0);
	endtask

	// Reset link lengths: zero, extremes, quadrant edges and shoulder+elbow wrap
	task automatic test_reset_lengths();
		send_angles(16'h0000, 16'h0000, 16'h0000);
		send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_angles(16'h8000, 16'h8000, 16'h8000);
		send_angles(16'h4000, 16'h3FFF, 16'hC000);
		send_angles(16'h3FFF, 16'h4000, 16'hBFFF);
		send_angles(16'hC000, 16'hBFFF, 16'h4000);
		send_angles(16'hBFFF, 16'hC000, 16'h3FFF);
		send_angles(16'h0001, 16'h7FFF, 16'h0001);
		send_angles(16'hFFFF, 16'h4000, 16'h4000);
		send_angles(16'h2000, 16'hE000, 16'hFFFF);
		send_angles(16'h5555, 16'hAAAA, 16'h5555);
		send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
		wait_drained();
	endtask

	// Longest and zero links
	task automatic test_length_extremes();
		set_lengths('1, '1, '1);
		send_angles(16'h0000, 16'h0000, 16'h0000);
		send_angles(16'h4000, 16'h4000, 16'h0000);
		send_angles(16'hC000, 16'hC000, 16'h0000);
		send_angles(16'h8000, 16'h0000, 16'h7FFF);
		send_angles(16'h2000, 16'h2000, 16'h2000);
		wait_drained();
		set_lengths('0, '0, '0);
		send_angles(16'h0000, 16'h0000, 16'h0000);
		send_angles(16'h7FFF, 16'h4000, 16'h8000);
		send_angles(16'h8000, 16'hC000, 16'h7FFF);
		wait_drained();
	endtask

	// A write to the unused index must leave every length alone
	task automatic test_spare_index();
		write_reg(REG_BASE_HEIGHT, 16'h1234, 1'b1);
		write_reg(REG_UPPER_LINK, 16'h8000, 1'b1);
		write_reg(REG_LOWER_LINK, 16'h4321, 1'b1);
		write_reg(REG_SPARE, '1, 1'b0);
		send_angles(16'h0000, 16'h1000, 16'h1000);
		send_angles(16'h6000, 16'hF000, 16'h3000);
		send_angles(16'hA000, 16'h7000, 16'h9000);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
		int sent;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_items) begin
			// fresh lengths for each chunk, written while the pipe is empty
			set_lengths(pick_length(), pick_length(), pick_length());
			for (int i = 0; i < CHUNK_ITEMS && sent < n_items; i++) begin
				send_angles(pick_angle(), pick_angle(), pick_angle());
				sent++;
			end
			wait_drained();
		end
	endtask

	// Output held off for a long stretch while input beats keep coming
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_lengths(pick_length(), pick_length(), pick_length());
		hold_go <= 1'b1;
		while (hold_left == 0) @(posedge clk);
		hold_go <= 1'b0;
		for (int i = 0; i < 80; i++) begin
			send_angles(pick_angle(), pick_angle(), pick_angle());
		end
		wait_drained();
	endtask

	initial begin
		arst_n               = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.base_angle     = '0;
		in_ch.shoulder_angle = '0;
		in_ch.elbow_angle    = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = REG_BASE_HEIGHT;
		cfg_ch.data          = '0;
		base_h               = LINK_AT_RESET;
		upper_l              = LINK_AT_RESET;
		lower_l              = LINK_AT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_lengths();
		test_length_extremes();
		test_spare_index();
		test_random_traffic(340, 24, 70);
		test_random_traffic(340, 70, 24);
		test_backpressure();
		test_random_traffic(340, 0, 0);

		// let any stray beats show up before the verdict
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/afk_pkg.sv
rtl/afk_intf.sv
rtl/afk_cordic.sv
rtl/afk_mac.sv
rtl/arm_forward_kinematics_3dof_core.sv
verif/tb.sv
